// ===== rtl/core/uvg_pkg.sv =====
// Shared types, codes and xoshiro256++ helpers for the identifier generator.
package uvg_pkg;

    localparam int WORD_W    = 64;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 42;
    localparam int TAIL_W    = 32;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Request kinds
    localparam logic [ACTION_W-1:0] ACT_V4     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_V7     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESEED = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED3 = 2'd3;

    // Seed values after reset
    localparam logic [WORD_W-1:0] SEED0_RST = 64'd1;
    localparam logic [WORD_W-1:0] SEED1_RST = 64'd2;
    localparam logic [WORD_W-1:0] SEED2_RST = 64'd3;
    localparam logic [WORD_W-1:0] SEED3_RST = 64'd4;

    localparam logic [3:0] V4_NIBBLE = 4'h4;
    localparam logic [3:0] V7_NIBBLE = 4'h7;
    localparam logic [1:0] VARIANT   = 2'b10;

    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
    } gen_state_t;

    typedef struct packed {
        logic                fire;
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   time_ms;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } result_t;

    // Output word of one draw: rotl(s0 + s3, 23) + s0
    function automatic logic [WORD_W-1:0] xo_out(input gen_state_t s);
        logic [WORD_W-1:0] sum;
        sum = s.w0 + s.w3;
        return {sum[40:0], sum[63:41]} + s.w0;
    endfunction

    // State after one draw
    function automatic gen_state_t xo_step(input gen_state_t s);
        gen_state_t n;
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] w3x;
        t    = {s.w1[46:0], 17'd0};
        n.w2 = s.w2 ^ s.w0;
        w3x  = s.w3 ^ s.w1;
        n.w1 = s.w1 ^ n.w2;
        n.w0 = s.w0 ^ w3x;
        n.w2 = n.w2 ^ t;
        n.w3 = {w3x[18:0], w3x[63:19]};
        return n;
    endfunction

    // Reverse the byte order of a word
    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/uvg_seed_regs.sv =====
// Seed register bank written through the configuration channel.
module uvg_seed_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [uvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uvg_pkg::WORD_W-1:0]      cfg_data,
    output logic                            cfg_ready,
    output uvg_pkg::gen_state_t             seeds
);
    import uvg_pkg::*;

    gen_state_t seed_reg;

    assign cfg_ready = 1'b1;
    assign seeds     = seed_reg;

    // Store a seed word on each write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg.w0 <= SEED0_RST;
            seed_reg.w1 <= SEED1_RST;
            seed_reg.w2 <= SEED2_RST;
            seed_reg.w3 <= SEED3_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SEED0: seed_reg.w0 <= cfg_data;
                CFG_SEED1: seed_reg.w1 <= cfg_data;
                CFG_SEED2: seed_reg.w2 <= cfg_data;
                CFG_SEED3: seed_reg.w3 <= cfg_data;
                default:   seed_reg    <= seed_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/uvg_gen.sv =====
// Generator state, timestamp and counter, with the identifier packing logic.
module uvg_gen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uvg_pkg::req_t        req,
    input  uvg_pkg::gen_state_t  seeds,
    output uvg_pkg::result_t     result
);
    import uvg_pkg::*;

    gen_state_t          gen_reg, gen_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [COUNT_W-1:0]  seq_reg, seq_next;

    gen_state_t          s1, s2;
    logic [WORD_W-1:0]   r1, r2;
    logic                newer;
    logic [COUNT_W-1:0]  cnt;
    logic [TAIL_W-1:0]   tail;
    logic [WORD_W-1:0]   sw1, sw2;

    // Two chained draws from the current state
    always_comb
    begin
        r1  = xo_out(gen_reg);
        s1  = xo_step(gen_reg);
        r2  = xo_out(s1);
        s2  = xo_step(s1);
        sw1 = swap_bytes(r1);
        sw2 = swap_bytes(r2);
    end

    // Pick next state and build the identifier
    always_comb
    begin
        gen_next       = gen_reg;
        last_time_next = last_time_reg;
        seq_next       = seq_reg;
        newer          = req.time_ms > last_time_reg;
        cnt            = newer ? r1[COUNT_W-1:0] : seq_reg + COUNT_W'(1);
        tail           = newer ? r2[TAIL_W-1:0] : r1[TAIL_W-1:0];
        result.hi      = '0;
        result.lo      = '0;
        case (req.action)
            ACT_V4:
            begin
                gen_next  = s2;
                result.hi = {sw1[63:16], V4_NIBBLE, sw1[11:0]};
                result.lo = {VARIANT, sw2[61:0]};
            end
            ACT_V7:
            begin
                gen_next       = newer ? s2 : s1;
                last_time_next = newer ? req.time_ms : last_time_reg;
                seq_next       = cnt;
                result.hi      = {req.time_ms, V7_NIBBLE, cnt[41:30]};
                result.lo      = {VARIANT, cnt[29:0], tail};
            end
            ACT_RESEED:
            begin
                gen_next = seeds;
            end
            default:
            begin
                gen_next = gen_reg;
            end
        endcase
    end

    // Commit state only for an item being processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg.w0    <= SEED0_RST;
            gen_reg.w1    <= SEED1_RST;
            gen_reg.w2    <= SEED2_RST;
            gen_reg.w3    <= SEED3_RST;
            last_time_reg <= '0;
            seq_reg       <= '0;
        end
        else if (req.fire)
        begin
            gen_reg       <= gen_next;
            last_time_reg <= last_time_next;
            seq_reg       <= seq_next;
        end
    end

endmodule

// ===== rtl/core/uuid_v4_v7_generator.sv =====
// Top level of the UUID v4/v7 generator: input register, generator, result register.
//
// Requests arrive on in_valid/in_ready with action (0 v4, 1 v7, 2 reseed)
// and time_ms (v7 only). Each request gives exactly one item on
// out_valid/out_ready carrying uuid_high and uuid_low; reseed and the
// unused action code return zeros.
// Seeds are written on cfg_valid/cfg_ready (always ready) with cfg_index
// 0..3 and cfg_data; they take effect at the next reseed item, and a reset
// brings them back to 1, 2, 3, 4.
// An accepted item sits in the input register, then the generator state update and
// identifier packing land in the result register, which drives out_valid.
// Throughput is one item per cycle while out_ready stays high, since both
// xoshiro256++ steps are combinational.
// At reset the generator loads seeds 1, 2, 3, 4, the last time and the
// sequence counter clear, and both channels come up empty.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, after which in_ready drops until out_ready.
module uuid_v4_v7_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [uvg_pkg::ACTION_W-1:0]    action,
    input  logic [uvg_pkg::TIME_W-1:0]      time_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [uvg_pkg::WORD_W-1:0]      uuid_high,
    output logic [uvg_pkg::WORD_W-1:0]      uuid_low,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uvg_pkg::WORD_W-1:0]      cfg_data
);
    import uvg_pkg::*;

    logic                in_valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [TIME_W-1:0]   time_reg;
    logic                out_valid_reg;
    result_t             result_reg;

    logic                advance;
    logic                fire;
    req_t                req;
    result_t             result;
    gen_state_t          seeds;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || fire;
    assign out_valid = out_valid_reg;
    assign uuid_high = result_reg.hi;
    assign uuid_low  = result_reg.lo;

    assign req.fire    = fire;
    assign req.action  = action_reg;
    assign req.time_ms = time_reg;

    uvg_seed_regs u_seed (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .seeds     (seeds)
    );

    uvg_gen u_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .seeds  (seeds),
        .result (result)
    );

    // Track input register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            time_reg   <= time_ms;
        end
    end

    // Hold result valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
        end
    end

    // Load the result item
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the UUID v4/v7 generator with its own xoshiro256++ predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code with no defined request; the block answers with zeros
    localparam logic [uvg_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam logic [63:0] CNT_MASK     = 64'h0000_03FF_FFFF_FFFF;
    // With word 0 at zero, this word 3 makes the first draw all ones in the counter bits
    localparam logic [63:0] WRAP_SEED    = (CNT_MASK >> 23) | (CNT_MASK << 41);
    localparam logic [63:0] ONES         = '1;
    localparam logic [47:0] MS_MAX       = '1;
    localparam int          LIMIT_CYCLES = 300000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          MAX_REPORTS  = 10;
    localparam int          PHASE_ITEMS  = 360;

    typedef enum logic {ROW_ITEM, ROW_SEED} row_kind_e;

    typedef struct {
        row_kind_e         kind;
        logic [1:0]        code;
        logic [47:0]       ms;
        logic [63:0]       word;
        bit                chk;
        uvg_pkg::result_t  ident;
    } row_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [uvg_pkg::ACTION_W-1:0]    action    = '0;
    logic [uvg_pkg::TIME_W-1:0]      time_ms   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [uvg_pkg::WORD_W-1:0]      uuid_high;
    logic [uvg_pkg::WORD_W-1:0]      uuid_low;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [uvg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [uvg_pkg::WORD_W-1:0]      cfg_data  = '0;

    // Predictor state
    logic [63:0] seed_reg [4];
    logic [63:0] gen_w [4];
    logic [47:0] last_ms;
    logic [41:0] seq_cnt;

    uvg_pkg::result_t ident_q [$];
    row_t             rows [$];
    logic [47:0]      cur_ms;
    int               errors    = 0;
    int               cycles    = 0;
    int               hold_reqs = 0;
    int               hold_seen = 0;
    int               hold_left = 0;
    bit               calm      = 1'b0;

    uuid_v4_v7_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .time_ms   (time_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .uuid_high (uuid_high),
        .uuid_low  (uuid_low),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Advance the generator by one step and return its output word
    function automatic logic [63:0] next_draw();
        logic [63:0] sum;
        logic [63:0] res;
        logic [63:0] shl;
        sum      = gen_w[0] + gen_w[3];
        res      = ((sum << 23) | (sum >> 41)) + gen_w[0];
        shl      = gen_w[1] << 17;
        gen_w[2] = gen_w[2] ^ gen_w[0];
        gen_w[3] = gen_w[3] ^ gen_w[1];
        gen_w[1] = gen_w[1] ^ gen_w[2];
        gen_w[0] = gen_w[0] ^ gen_w[3];
        gen_w[2] = gen_w[2] ^ shl;
        gen_w[3] = (gen_w[3] << 45) | (gen_w[3] >> 19);
        return res;
    endfunction

    function automatic logic [63:0] byte_rev(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Work out the identifier for one request and update the predictor state
    function automatic uvg_pkg::result_t predict_ident(input logic [1:0] act,
                                                       input logic [47:0] ms);
        uvg_pkg::result_t r;
        logic [63:0]      a;
        logic [63:0]      b;
        r = '0;
        case (act)
            uvg_pkg::ACT_V4:
            begin
                a              = next_draw();
                b              = next_draw();
                r.hi           = byte_rev(a);
                r.hi[15:12]    = uvg_pkg::V4_NIBBLE;
                r.lo           = byte_rev(b);
                r.lo[63:62]    = uvg_pkg::VARIANT;
            end
            uvg_pkg::ACT_V7:
            begin
                // Reload the counter on a newer time, else bump it with wrap
                if (ms > last_ms)
                begin
                    last_ms = ms;
                    a       = next_draw();
                    seq_cnt = a[41:0];
                end
                else
                begin
                    seq_cnt = seq_cnt + 42'd1;
                end
                b    = next_draw();
                r.hi = {ms, uvg_pkg::V7_NIBBLE, seq_cnt[41:30]};
                r.lo = {uvg_pkg::VARIANT, seq_cnt[29:0], b[31:0]};
            end
            uvg_pkg::ACT_RESEED:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    gen_w[i] = seed_reg[i];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    // Check each accepted item and pace the receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin : rx
            uvg_pkg::result_t want;
            if (out_valid && out_ready)
            begin
                if (ident_q.size() == 0)
                begin
                    note_mismatch("unexpected item, uuid_high", '0, uuid_high);
                end
                else
                begin
                    want = ident_q.pop_front();
                    if (uuid_high !== want.hi)
                    begin
                        note_mismatch("uuid_high", want.hi, uuid_high);
                    end
                    if (uuid_low !== want.lo)
                    begin
                        note_mismatch("uuid_low", want.lo, uuid_low);
                    end
                end
            end
            // Hold off for a long stretch on request, else stall at random unless calm is set
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_seen != hold_reqs)
            begin
                hold_seen++;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("uuid_v4_v7_generator: mismatch");
            $finish;
        end
    end

    // Offer one item, wait for it to be taken, then record what it should give
    task automatic send_req(input logic [1:0] act, input logic [47:0] ms,
                            input bit chk, input uvg_pkg::result_t typed);
        int               gap;
        uvg_pkg::result_t pred;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        time_ms  <= ms;
        do @(posedge clk); while (!in_ready);
        pred = predict_ident(act, ms);
        ident_q.push_back(chk ? typed : pred);
    endtask

    // Stop sending and wait until every expected item is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ident_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        seed_reg[idx] = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_seeds(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3);
        drain();
        write_seed(uvg_pkg::CFG_SEED0, w0);
        write_seed(uvg_pkg::CFG_SEED1, w1);
        write_seed(uvg_pkg::CFG_SEED2, w2);
        write_seed(uvg_pkg::CFG_SEED3, w3);
        send_req(uvg_pkg::ACT_RESEED, '0, 1'b1, '0);
    endtask

    task automatic add_row(input row_kind_e k, input logic [1:0] code,
                           input logic [47:0] ms, input logic [63:0] word,
                           input bit chk, input logic [63:0] hi, input logic [63:0] lo);
        row_t r;
        r.kind     = k;
        r.code     = code;
        r.ms       = ms;
        r.word     = word;
        r.chk      = chk;
        r.ident.hi = hi;
        r.ident.lo = lo;
        rows.push_back(r);
    endtask

    task automatic run_rows(input int first, input int last);
        for (int i = first; i <= last; i++)
        begin
            if (rows[i].kind == ROW_SEED)
            begin
                drain();
                write_seed(rows[i].code, rows[i].word);
            end
            else
            begin
                send_req(rows[i].code, rows[i].ms, rows[i].chk, rows[i].ident);
            end
        end
    endtask

    // Pick a random request; v7 times walk forward or repeat, sometimes go back
    task automatic rand_item();
        int          pick;
        int          sel;
        logic [1:0]  act;
        logic [47:0] ms;
        pick = $urandom_range(0, 99);
        ms   = {16'($urandom), 32'($urandom)};
        if (pick < 45)
        begin
            act = uvg_pkg::ACT_V4;
        end
        else if (pick < 88)
        begin
            act = uvg_pkg::ACT_V7;
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                cur_ms += $urandom_range(1, 3);
            end
            else if (sel < 45)
            begin
                cur_ms += $urandom;
            end
            if (sel < 90)
            begin
                ms = cur_ms;
            end
            else
            begin
                ms = ms % cur_ms;
            end
        end
        else if (pick < 95)
        begin
            act = uvg_pkg::ACT_RESEED;
        end
        else
        begin
            act = ACT_NONE;
        end
        send_req(act, ms, 1'b0, '0);
    endtask

    initial
    begin : main
        int tail_row;

        seed_reg[0] = uvg_pkg::SEED0_RST;
        seed_reg[1] = uvg_pkg::SEED1_RST;
        seed_reg[2] = uvg_pkg::SEED2_RST;
        seed_reg[3] = uvg_pkg::SEED3_RST;
        for (int i = 0; i < 4; i++)
        begin
            gen_w[i] = seed_reg[i];
        end
        last_ms = '0;
        seq_cnt = '0;
        cur_ms  = 48'd1000;

        // Opening rows: reset seeds, time ordering cases, zero answers
        add_row(ROW_ITEM, uvg_pkg::ACT_V4, 48'd0, 64'd0, 1'b1,
                64'h0100_8002_0000_4000, 64'hA700_8003_0000_0000);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd5, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd5, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd3, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_RESEED, MS_MAX, 64'd0, 1'b1, '0, '0);
        add_row(ROW_ITEM, ACT_NONE, MS_MAX, 64'd0, 1'b1, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V4, MS_MAX, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd6, 64'd0, 1'b0, '0, '0);
        // Counter reloads to all ones, then wraps to zero
        add_row(ROW_SEED, uvg_pkg::CFG_SEED0, '0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED1, '0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED2, '0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED3, '0, WRAP_SEED, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_RESEED, 48'd0, 64'd0, 1'b1, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd7, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd7, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd7, 64'd0, 1'b0, '0, '0);
        tail_row = rows.size();
        // Closing rows: all-zero seed, largest time, all-ones seed
        add_row(ROW_SEED, uvg_pkg::CFG_SEED0, '0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED1, '0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED2, '0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED3, '0, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_RESEED, 48'd0, 64'd0, 1'b1, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V4, 48'd0, 64'd0, 1'b1,
                64'h0000_0000_0000_4000, 64'h8000_0000_0000_0000);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, MS_MAX, 64'd0, 1'b1,
                64'hFFFF_FFFF_FFFF_7000, 64'h8000_0000_0000_0000);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, MS_MAX, 64'd0, 1'b1,
                64'hFFFF_FFFF_FFFF_7000, 64'h8000_0001_0000_0000);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, 48'd0, 64'd0, 1'b1,
                64'h0000_0000_0000_7000, 64'h8000_0002_0000_0000);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED0, '0, ONES, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED1, '0, ONES, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED2, '0, ONES, 1'b0, '0, '0);
        add_row(ROW_SEED, uvg_pkg::CFG_SEED3, '0, ONES, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_RESEED, 48'd0, 64'd0, 1'b1, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V4, MS_MAX, 64'd0, 1'b0, '0, '0);
        add_row(ROW_ITEM, uvg_pkg::ACT_V7, MS_MAX, 64'd0, 1'b0, '0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_rows(0, tail_row - 1);

        // Random seeds; hold the receiver off mid-way so the block backs up
        load_seeds(rand64(), rand64(), rand64(), rand64());
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 2)
            begin
                hold_reqs++;
            end
            rand_item();
        end

        // All-ones seeds with no idling on either side
        load_seeds(ONES, ONES, ONES, ONES);
        calm = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            rand_item();
        end
        calm = 1'b0;

        // Random seeds with one zero word; pause the sender until all is back
        load_seeds(rand64(), rand64(), 64'd0, rand64());
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 2)
            begin
                drain();
            end
            rand_item();
        end

        // Back to the reset seeds, with another long hold
        load_seeds(uvg_pkg::SEED0_RST, uvg_pkg::SEED1_RST,
                   uvg_pkg::SEED2_RST, uvg_pkg::SEED3_RST);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 3)
            begin
                hold_reqs++;
            end
            rand_item();
        end

        run_rows(tail_row, rows.size() - 1);

        in_valid <= 1'b0;
        while (ident_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && ident_q.size() == 0)
        begin
            $display("uuid_v4_v7_generator: match");
        end
        else
        begin
            $display("uuid_v4_v7_generator: mismatch");
        end
        $finish;
    end

endmodule
